// ===== rtl/core/bps_pkg.sv =====
// Package for the buzzer pattern sequencer: queue entry type, queue control
// struct, phase codes and reset constants. No dependencies.
package bps_pkg;

    // Number of patterns the queue holds
    localparam int QUEUE_DEPTH = 4;

    // Reset value of the poll period register
    localparam logic [7:0] POLL_PERIOD_RESET = 8'd20;

    // Sequencer phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_BEEP  = 2'd2;
    localparam logic [1:0] PH_GAP   = 2'd3;

    // One queued beep pattern
    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] length;
        logic [7:0]  repeats;
        logic [15:0] gap;
        logic [31:0] delay;
    } entry_t;

    // Queue control broadcast to every cell
    typedef struct packed {
        logic shift;   // pop: every cell takes its neighbor's entry
        logic push;    // push: first free cell loads the new entry
    } queue_ctrl_t;

endpackage

// ===== rtl/core/bps_cell.sv =====
// One storage cell of the pattern queue shift chain.
// Depends on bps_pkg (entry_t, queue_ctrl_t).
module bps_cell
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_ctrl_t ctrl,
    input  entry_t      push_entry,
    input  logic        prev_valid,
    input  logic        next_valid,
    input  entry_t      next_entry,
    output logic        valid,
    output entry_t      entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   load_push;

    // This cell is the first free one when it is empty and its predecessor is full
    assign load_push = ctrl.push && !valid_reg && prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
        else if (load_push)
        begin
            valid_next = 1'b1;
            entry_next = push_entry;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== rtl/core/bps_seq.sv =====
// Beep sequencer: poll timer, phase machine and current pattern registers.
// Depends on bps_pkg (phase codes, entry_t).
module bps_seq
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic [7:0]  poll_period,
    input  logic        head_valid,
    input  entry_t      head_entry,
    output logic        pop,
    output logic        tone_start,
    output logic [15:0] tone_freq_out,
    output logic [15:0] tone_len_out,
    output logic        busy_next
);

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] poll_elapsed_reg, poll_elapsed_next;
    logic [31:0] ref_elapsed_reg, ref_elapsed_next;
    logic [7:0]  beeps_done_reg, beeps_done_next;
    logic [15:0] cur_freq_reg, cur_length_reg;
    logic [7:0]  cur_repeats_reg;
    logic [31:0] cur_delay_reg;
    logic [16:0] cur_wait_reg;
    logic [31:0] poll_inc;
    logic [31:0] ref_inc;
    logic [7:0]  beeps_inc;
    logic        evaluate;

    // Elapsed times since last poll and since reference point, after this tick
    assign poll_inc  = poll_elapsed_reg + 32'd1;
    assign ref_inc   = ref_elapsed_reg + 32'd1;
    assign beeps_inc = beeps_done_reg + 8'd1;
    assign evaluate  = tick && (poll_inc >= {24'd0, poll_period});

    // Phase machine
    always_comb
    begin
        phase_next        = phase_reg;
        poll_elapsed_next = poll_elapsed_reg;
        ref_elapsed_next  = ref_elapsed_reg;
        beeps_done_next   = beeps_done_reg;
        pop               = 1'b0;
        tone_start        = 1'b0;
        if (tick)
        begin
            poll_elapsed_next = evaluate ? 32'd0 : poll_inc;
            ref_elapsed_next  = ref_inc;
        end
        if (evaluate)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (head_valid)
                    begin
                        pop             = 1'b1;
                        beeps_done_next = 8'd0;
                        if (head_entry.delay != 32'd0)
                        begin
                            ref_elapsed_next = 32'd0;
                            phase_next       = PH_DELAY;
                        end
                        else
                        begin
                            phase_next = PH_BEEP;
                        end
                    end
                end
                PH_DELAY:
                begin
                    if (ref_inc >= cur_delay_reg)
                    begin
                        phase_next = PH_BEEP;
                    end
                end
                PH_BEEP:
                begin
                    tone_start       = 1'b1;
                    ref_elapsed_next = 32'd0;
                    phase_next       = PH_GAP;
                end
                PH_GAP:
                begin
                    if (ref_inc >= {15'd0, cur_wait_reg})
                    begin
                        beeps_done_next = beeps_inc;
                        phase_next = (beeps_inc >= cur_repeats_reg) ? PH_IDLE : PH_BEEP;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            poll_elapsed_reg <= 32'd0;
            ref_elapsed_reg  <= 32'd0;
            beeps_done_reg   <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            poll_elapsed_reg <= poll_elapsed_next;
            ref_elapsed_reg  <= ref_elapsed_next;
            beeps_done_reg   <= beeps_done_next;
        end
    end

    // Current pattern, loaded on pop; tone plus gap summed here
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_freq_reg    <= head_entry.freq;
            cur_length_reg  <= head_entry.length;
            cur_repeats_reg <= head_entry.repeats;
            cur_delay_reg   <= head_entry.delay;
            cur_wait_reg    <= {1'b0, head_entry.length} + {1'b0, head_entry.gap};
        end
    end

    assign tone_freq_out = tone_start ? cur_freq_reg : 16'd0;
    assign tone_len_out  = tone_start ? cur_length_reg : 16'd0;
    assign busy_next     = (phase_next != PH_IDLE);

    // Checks
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && phase_reg == PH_IDLE)
        else $error("pop without a queued pattern");

    a_tone_leads_to_gap: assert property (@(posedge clk) disable iff (!rst_n)
        tone_start |=> phase_reg == PH_GAP && ref_elapsed_reg == 32'd0)
        else $error("tone start did not enter gap wait");

    a_no_eval_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> $stable(phase_reg) && $stable(poll_elapsed_reg))
        else $error("sequencer state moved without a tick");

endmodule

// ===== rtl/core/buzzer_pattern_sequencer_unit.sv =====
// Top level of the buzzer pattern sequencer: request channels, poll period
// register, pattern queue chain and output register.
// Depends on bps_pkg, bps_cell, bps_seq.
//
// Takes one request per clock while the receiver does not stall: a millisecond
// tick or a pattern push. Every request yields exactly one result, held in an
// output register and shown in the cycle after acceptance; a new request is
// taken in the same cycle that the previous result is taken, which sustains
// that rate. Patterns wait in a QUEUE_DEPTH-deep chain of cells that shifts
// toward the head on each pop; a push to a full chain is dropped and reported.
// Timing is kept as elapsed-millisecond counters, one increment per tick.
module buzzer_pattern_sequencer_unit
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] tone_freq,
    input  logic [15:0] tone_ms,
    input  logic [7:0]  beep_count,
    input  logic [15:0] gap_ms,
    input  logic [31:0] start_delay_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        push_accepted,
    output logic        tone_start,
    output logic [15:0] out_freq,
    output logic [15:0] out_length_ms,
    output logic        sequencer_busy
);

    logic [7:0]  poll_period_reg;
    logic        accept;
    logic        tick;
    logic        push_ok;
    logic        pop;
    logic        seq_tone;
    logic [15:0] seq_freq;
    logic [15:0] seq_len;
    logic        seq_busy;
    queue_ctrl_t qctrl;
    entry_t      push_entry;
    logic        cell_valid [QUEUE_DEPTH];
    entry_t      cell_entry [QUEUE_DEPTH];

    logic        out_valid_reg;
    logic        push_accepted_reg;
    logic        tone_start_reg;
    logic [15:0] out_freq_reg;
    logic [15:0] out_length_reg;
    logic        busy_reg;

    // Handshake: the output register frees when empty or being taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tick     = accept && !operation;
    assign push_ok  = accept && operation && !cell_valid[QUEUE_DEPTH-1];

    // Poll period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_period_reg <= POLL_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            poll_period_reg <= cfg_wr_data;
        end
    end

    // Pattern queue chain
    assign push_entry = '{freq: tone_freq, length: tone_ms, repeats: beep_count,
                          gap: gap_ms, delay: start_delay_ms};
    assign qctrl.shift = pop;
    assign qctrl.push  = push_ok;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   prev_v;
        logic   next_v;
        entry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_rest
            assign prev_v = cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_v = 1'b0;
            assign next_e = '0;
        end
        else
        begin : g_mid
            assign next_v = cell_valid[i+1];
            assign next_e = cell_entry[i+1];
        end

        bps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (qctrl),
            .push_entry (push_entry),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_entry (next_e),
            .valid      (cell_valid[i]),
            .entry      (cell_entry[i])
        );
    end

    // Sequencer
    bps_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .poll_period   (poll_period_reg),
        .head_valid    (cell_valid[0]),
        .head_entry    (cell_entry[0]),
        .pop           (pop),
        .tone_start    (seq_tone),
        .tone_freq_out (seq_freq),
        .tone_len_out  (seq_len),
        .busy_next     (seq_busy)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            push_accepted_reg <= push_ok;
            tone_start_reg    <= seq_tone;
            out_freq_reg      <= seq_freq;
            out_length_reg    <= seq_len;
            busy_reg          <= seq_busy;
        end
    end

    assign out_valid      = out_valid_reg;
    assign push_accepted  = push_accepted_reg;
    assign tone_start     = tone_start_reg;
    assign out_freq       = out_freq_reg;
    assign out_length_ms  = out_length_reg;
    assign sequencer_busy = busy_reg;

    // Checks
    a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_ok && pop))
        else $error("push and pop in the same cycle");

    a_full_push_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation && cell_valid[QUEUE_DEPTH-1] |=> !push_accepted)
        else $error("push to a full queue reported as accepted");

    a_tone_has_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tone_start |-> sequencer_busy)
        else $error("tone start while sequencer idle");

endmodule

// ===== dv/buzzer_pattern_sequencer_unit_test.sv =====
// Self-checking testbench for buzzer_pattern_sequencer_unit: request driver, result monitor,
// an in-line predictor of the beep sequencer and a stall watchdog.
// Depends on bps_pkg and the buzzer_pattern_sequencer_unit RTL.
module buzzer_pattern_sequencer_unit_test;
    import bps_pkg::*;

    // Request operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    localparam int HOLD_CYCLES = 64;
    localparam int STUCK_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic   op;
        entry_t pat;
    } beep_req_t;

    typedef struct packed {
        logic        push_ok;
        logic        tone;
        logic [15:0] freq;
        logic [15:0] length;
        logic        busy;
    } beep_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = OP_TICK;
    logic [15:0] tone_freq = 16'd0;
    logic [15:0] tone_ms = 16'd0;
    logic [7:0]  beep_count = 8'd0;
    logic [15:0] gap_ms = 16'd0;
    logic [31:0] start_delay_ms = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        push_accepted;
    logic        tone_start;
    logic [15:0] out_freq;
    logic [15:0] out_length_ms;
    logic        sequencer_busy;

    // Request backlog and expected results
    beep_req_t    request_backlog[$];
    beep_result_t beep_results_due[$];

    // Predictor state
    entry_t      pattern_fifo[$];
    entry_t      playing = '0;
    logic [7:0]  poll_ms = POLL_PERIOD_RESET;
    logic [31:0] model_ms = 32'd0;
    logic [31:0] last_eval_ms = 32'd0;
    logic [31:0] mark_ms = 32'd0;
    logic [1:0]  seq_phase = PH_IDLE;
    logic [7:0]  beeps_played = 8'd0;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int session_poll = 0;
    int items_queued = 0;
    int results_seen = 0;
    int mismatches = 0;
    int hold_left = 0;
    int next_hold_at = 300;
    int stuck_cycles = 0;

    buzzer_pattern_sequencer_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .tone_freq      (tone_freq),
        .tone_ms        (tone_ms),
        .beep_count     (beep_count),
        .gap_ms         (gap_ms),
        .start_delay_ms (start_delay_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .push_accepted  (push_accepted),
        .tone_start     (tone_start),
        .out_freq       (out_freq),
        .out_length_ms  (out_length_ms),
        .sequencer_busy (sequencer_busy)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor: one request in, one result out
    function automatic beep_result_t predict_beep_step(beep_req_t req);
        beep_result_t res;
        logic [31:0]  elapsed;
        res = '0;
        if (req.op == OP_PUSH)
        begin
            if (pattern_fifo.size() < QUEUE_DEPTH)
            begin
                pattern_fifo.push_back(req.pat);
                res.push_ok = 1'b1;
            end
        end
        else
        begin
            model_ms = model_ms + 32'd1;
            if (model_ms - last_eval_ms >= {24'd0, poll_ms})
            begin
                last_eval_ms = model_ms;
                elapsed = model_ms - mark_ms;
                case (seq_phase)
                    PH_IDLE:
                    begin
                        if (pattern_fifo.size() != 0)
                        begin
                            playing = pattern_fifo.pop_front();
                            beeps_played = 8'd0;
                            if (playing.delay != 32'd0)
                            begin
                                mark_ms = model_ms;
                                seq_phase = PH_DELAY;
                            end
                            else
                                seq_phase = PH_BEEP;
                        end
                    end
                    PH_DELAY:
                    begin
                        if (elapsed >= playing.delay)
                            seq_phase = PH_BEEP;
                    end
                    PH_BEEP:
                    begin
                        mark_ms = model_ms;
                        seq_phase = PH_GAP;
                        res.tone = 1'b1;
                        res.freq = playing.freq;
                        res.length = playing.length;
                    end
                    default:
                    begin
                        // tone plus gap, summed without wrap
                        if (elapsed >= {16'd0, playing.length} + {16'd0, playing.gap})
                        begin
                            beeps_played = beeps_played + 8'd1;
                            seq_phase = (beeps_played >= playing.repeats) ? PH_IDLE : PH_BEEP;
                        end
                    end
                endcase
            end
        end
        res.busy = (seq_phase != PH_IDLE);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    endtask

    // Request driver
    always @(posedge clk)
    begin
        beep_req_t req;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                req.op = operation;
                req.pat.freq = tone_freq;
                req.pat.length = tone_ms;
                req.pat.repeats = beep_count;
                req.pat.gap = gap_ms;
                req.pat.delay = start_delay_ms;
                beep_results_due.push_back(predict_beep_step(req));
            end
            if (!in_valid || !in_stall)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    req = request_backlog.pop_front();
                    in_valid <= 1'b1;
                    operation <= req.op;
                    tone_freq <= req.pat.freq;
                    tone_ms <= req.pat.length;
                    beep_count <= req.pat.repeats;
                    gap_ms <= req.pat.gap;
                    start_delay_ms <= req.pat.delay;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall, with a long hold-off now and then
    always @(posedge clk)
    begin
        beep_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (beep_results_due.size() == 0)
                    report_mismatch("result with nothing expected", 32'd0, 32'd0);
                else
                begin
                    want = beep_results_due.pop_front();
                    if (push_accepted !== want.push_ok)
                        report_mismatch("push_accepted", push_accepted, want.push_ok);
                    if (tone_start !== want.tone)
                        report_mismatch("tone_start", tone_start, want.tone);
                    if (out_freq !== want.freq)
                        report_mismatch("out_freq", out_freq, want.freq);
                    if (out_length_ms !== want.length)
                        report_mismatch("out_length_ms", out_length_ms, want.length);
                    if (sequencer_busy !== want.busy)
                        report_mismatch("sequencer_busy", sequencer_busy, want.busy);
                end
                results_seen++;
            end
            if (hold_left == 0 && results_seen >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 700;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Watchdog: cycles with work outstanding but no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (request_backlog.size() == 0 && !in_valid && beep_results_due.size() == 0))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic queue_request(logic op, entry_t pat);
        beep_req_t req;
        req.op = op;
        req.pat = pat;
        request_backlog.push_back(req);
        items_queued++;
    endtask

    // Ticks carry random junk in the pattern fields
    task automatic queue_ticks(int n);
        entry_t junk;
        repeat (n)
        begin
            junk.freq = 16'($urandom);
            junk.length = 16'($urandom);
            junk.repeats = 8'($urandom);
            junk.gap = 16'($urandom);
            junk.delay = $urandom;
            queue_request(OP_TICK, junk);
        end
    endtask

    function automatic entry_t small_pattern();
        entry_t pat;
        pat.freq = 16'($urandom);
        pat.length = 16'($urandom_range(8));
        pat.repeats = 8'($urandom_range(4));
        pat.gap = 16'($urandom_range(8));
        pat.delay = ($urandom_range(1) == 0) ? 32'd0 : 32'($urandom_range(12, 1));
        return pat;
    endfunction

    task automatic wait_drained();
        while (request_backlog.size() != 0 || in_valid || beep_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then set idling and write the poll period
    task automatic start_session(logic [7:0] poll, int snd_pct, int rcv_pct);
        wait_drained();
        repeat (4) @(posedge clk);
        sender_idle_pct = snd_pct;
        receiver_idle_pct = rcv_pct;
        session_poll = poll;
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= poll;
        poll_ms = poll;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly whole patterns followed by enough ticks to play them,
    // plus overflow bursts and bare tick noise
    task automatic fill_random(int n_items);
        int     target;
        int     pick;
        int     span;
        int     beeps;
        entry_t pat;
        target = items_queued + n_items;
        while (items_queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                span = 0;
                repeat ($urandom_range(3, 1))
                begin
                    pat = small_pattern();
                    beeps = (pat.repeats == 0) ? 1 : pat.repeats;
                    span += pat.delay + beeps * (pat.length + pat.gap)
                            + (3 + 2 * beeps) * (session_poll + 1);
                    queue_request(OP_PUSH, pat);
                end
                queue_ticks(span * $urandom_range(110, 60) / 100 + 1);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(6, 5))
                    queue_request(OP_PUSH, small_pattern());
            end
            else
                queue_ticks($urandom_range(20, 1));
        end
    endtask

    initial
    begin
        entry_t pat;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero poll period, zero beep count, start delay,
        // full queue drop with every pattern field at its maximum
        start_session(8'd0, 32, 52);
        pat = '{freq: 16'hFFFF, length: 16'd1, repeats: 8'd0, gap: 16'd0, delay: 32'd0};
        queue_request(OP_PUSH, pat);
        pat = '{freq: 16'h0000, length: 16'd0, repeats: 8'd2, gap: 16'd1, delay: 32'd3};
        queue_request(OP_PUSH, pat);
        pat = '{freq: 16'h1234, length: 16'd2, repeats: 8'd1, gap: 16'd0, delay: 32'd0};
        queue_request(OP_PUSH, pat);
        queue_request(OP_PUSH, '0);
        queue_request(OP_PUSH, '1);
        queue_request(OP_TICK, '1);
        queue_request(OP_TICK, '0);
        queue_ticks(16);

        // Largest poll period: one short pattern, enough ticks for its tone
        start_session(8'd255, 32, 52);
        pat = '0;
        pat.freq = 16'($urandom);
        queue_request(OP_PUSH, pat);
        queue_ticks(520);

        // Each batch overshoots its count by up to one pattern group
        start_session(8'd0, 32, 52);
        fill_random(30);
        start_session(8'd1, 32, 52);
        fill_random(30);
        start_session(8'd3, 52, 32);
        fill_random(30);
        start_session(8'd20, 52, 32);
        fill_random(10);
        start_session(8'd2, 0, 0);
        fill_random(30);
        start_session(8'd0, 0, 0);
        fill_random(20);
        start_session(8'd7, 0, 0);
        fill_random(10);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
